FILE: rtl/dzv_pkg.sv
package dzv_pkg;

    // Largest logical frame length the block handles at all
    localparam logic [23:0] MAX_FRAME_BYTES = 24'd65535;

    localparam int unsigned LEN_W   = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned WCNT_W  = 14;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Reset value of the capacity register
    localparam logic [LEN_W-1:0] CAPACITY_RESET = 16'hFFFF;

    // Byte counts carried with a result
    localparam logic [2:0] NBYTES_NONE = 3'd0;
    localparam logic [2:0] NBYTES_TAIL = 3'd1;
    localparam logic [2:0] NBYTES_WORD = 3'd4;

    // Last byte index of a varint group
    localparam logic [2:0] GROUP_LAST = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_PARSE  = 2'd1,
        STATUS_BOUNDS = 2'd2
    } status_t;

    // One classified stored byte, as queued between front and back
    typedef struct packed {
        logic [7:0]       stored_byte;
        logic             end_of_stream;
        logic [LEN_W-1:0] logical_length;
        logic             cap_err;
    } item_t;

    // Place the 7 payload bits of a group byte at their position; bits
    // beyond the word are dropped.
    function automatic logic [WORD_W-1:0] group_bits(input logic [6:0] bits,
                                                     input logic [2:0] idx);
        logic [WORD_W-1:0] r;
        case (idx)
            3'd0:    r = {25'd0, bits};
            3'd1:    r = {18'd0, bits, 7'd0};
            3'd2:    r = {11'd0, bits, 14'd0};
            3'd3:    r = {4'd0, bits, 21'd0};
            default: r = {bits[3:0], 28'd0};
        endcase
        return r;
    endfunction

    // Zigzag back to two's complement
    function automatic logic [WORD_W-1:0] unzigzag(input logic [WORD_W-1:0] z);
        return (z >> 1) ^ {WORD_W{z[0]}};
    endfunction

endpackage

FILE: rtl/dzv_front.sv
module dzv_front (
    input  logic                       clk,
    input  logic                       rst_n,
    // item channel
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [7:0]                 stored_byte,
    input  logic                       end_of_stream,
    input  logic [dzv_pkg::LEN_W-1:0]  logical_length,
    // configuration channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dzv_pkg::LEN_W-1:0]  output_capacity,
    // queue read side
    output logic                       q_valid,
    output dzv_pkg::item_t             q_item,
    input  logic                       q_pop
);
    import dzv_pkg::*;

    logic [LEN_W-1:0]  capacity_reg;
    item_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    item_t             in_item;

    // capacity register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAPACITY_RESET;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= output_capacity;
    end

    // classify the incoming byte
    always_comb
    begin
        in_item.stored_byte    = stored_byte;
        in_item.end_of_stream  = end_of_stream;
        in_item.logical_length = logical_length;
        in_item.cap_err        = (logical_length > capacity_reg) ||
                                 ({8'd0, logical_length} > MAX_FRAME_BYTES);
    end

    // queue control
    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != '0);
    assign q_item     = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
            count_next = QCNT_W'(count_reg + 1'b1);
        else if (!push && q_pop)
            count_next = QCNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= in_item;
    end

endmodule

FILE: rtl/dzv_back.sv
module dzv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    // queue read side
    input  logic                        q_valid,
    input  dzv_pkg::item_t              q_item,
    output logic                        q_pop,
    // result channel
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [dzv_pkg::WORD_W-1:0]  data,
    output logic [2:0]                  valid_bytes,
    output logic [1:0]                  status,
    output logic                        frame_done
);
    import dzv_pkg::*;

    logic [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] accum_reg, accum_next;
    logic [2:0]        gidx_reg, gidx_next;
    logic [WCNT_W-1:0] words_reg, words_next;
    logic [1:0]        tail_reg, tail_next;
    logic              active_reg, active_next;
    logic              discard_reg, discard_next;

    logic              res_valid_reg, res_valid_next;
    logic [WORD_W-1:0] res_data_reg, res_data_next;
    logic [2:0]        res_nb_reg, res_nb_next;
    status_t           res_status_reg, res_status_next;
    logic              res_done_reg, res_done_next;

    logic              res_fire;
    logic              out_free;

    // take a queued byte whenever the result register can be refilled
    assign out_free = !res_valid_reg || !result_stall;
    assign q_pop    = q_valid && out_free;

    // decode one byte
    always_comb
    begin
        logic              proceed;
        logic              raise;
        status_t           err_code;
        logic              eos;
        logic [7:0]        b;

        eos      = q_item.end_of_stream;
        b        = q_item.stored_byte;
        proceed  = 1'b0;
        raise    = 1'b0;
        err_code = STATUS_PARSE;

        prev_next    = prev_reg;
        accum_next   = accum_reg;
        gidx_next    = gidx_reg;
        words_next   = words_reg;
        tail_next    = tail_reg;
        active_next  = active_reg;
        discard_next = discard_reg;

        res_fire        = 1'b0;
        res_data_next   = '0;
        res_nb_next     = NBYTES_NONE;
        res_status_next = STATUS_OK;
        res_done_next   = 1'b0;

        if (q_pop)
        begin
            proceed = 1'b1;
            // frame start or discard
            if (!active_reg)
            begin
                active_next  = 1'b1;
                discard_next = 1'b0;
                prev_next    = '0;
                accum_next   = '0;
                gidx_next    = '0;
                words_next   = '0;
                tail_next    = '0;
                if (q_item.cap_err)
                begin
                    raise    = 1'b1;
                    err_code = STATUS_BOUNDS;
                    proceed  = 1'b0;
                end
                else
                begin
                    words_next = q_item.logical_length[LEN_W-1:2];
                    tail_next  = q_item.logical_length[1:0];
                end
            end
            else if (discard_reg)
            begin
                proceed = 1'b0;
                if (eos)
                begin
                    active_next  = 1'b0;
                    discard_next = 1'b0;
                end
            end

            if (proceed)
            begin
                if (words_next != '0)
                begin
                    // varint group byte
                    accum_next = accum_next | group_bits(b[6:0], gidx_next);
                    if (b[7])
                    begin
                        if (gidx_next >= GROUP_LAST || eos)
                            raise = 1'b1;
                        else
                            gidx_next = 3'(gidx_next + 3'd1);
                    end
                    else
                    begin
                        prev_next  = prev_next + unzigzag(accum_next);
                        accum_next = '0;
                        gidx_next  = '0;
                        words_next = WCNT_W'(words_next - 1'b1);
                        if (eos && !(words_next == '0 && tail_next == '0))
                            raise = 1'b1;
                        else
                        begin
                            res_fire      = 1'b1;
                            res_data_next = prev_next;
                            res_nb_next   = NBYTES_WORD;
                            res_done_next = eos;
                            if (eos)
                                active_next = 1'b0;
                        end
                    end
                end
                else if (tail_next != '0)
                begin
                    // verbatim tail byte
                    tail_next = 2'(tail_next - 1'b1);
                    if (eos && tail_next != '0)
                        raise = 1'b1;
                    else
                    begin
                        res_fire      = 1'b1;
                        res_data_next = {24'd0, b};
                        res_nb_next   = NBYTES_TAIL;
                        res_done_next = eos;
                        if (eos)
                            active_next = 1'b0;
                    end
                end
                else
                begin
                    // leftover byte
                    raise = 1'b1;
                end
            end

            // error ends the frame with a status-only result
            if (raise)
            begin
                res_fire        = 1'b1;
                res_data_next   = '0;
                res_nb_next     = NBYTES_NONE;
                res_status_next = err_code;
                res_done_next   = 1'b1;
                if (eos)
                begin
                    active_next  = 1'b0;
                    discard_next = 1'b0;
                end
                else
                    discard_next = 1'b1;
            end
        end
    end

    // result register valid
    assign res_valid_next = q_pop ? res_fire : (res_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            accum_reg     <= '0;
            gidx_reg      <= '0;
            words_reg     <= '0;
            tail_reg      <= '0;
            active_reg    <= 1'b0;
            discard_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            accum_reg     <= accum_next;
            gidx_reg      <= gidx_next;
            words_reg     <= words_next;
            tail_reg      <= tail_next;
            active_reg    <= active_next;
            discard_reg   <= discard_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (q_pop && res_fire)
        begin
            res_data_reg   <= res_data_next;
            res_nb_reg     <= res_nb_next;
            res_status_reg <= res_status_next;
            res_done_reg   <= res_done_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign data         = res_data_reg;
    assign valid_bytes  = res_nb_reg;
    assign status       = res_status_reg;
    assign frame_done   = res_done_reg;

endmodule

FILE: rtl/delta_zigzag_varint_decoder.sv
// Delta/zigzag/varint frame decoder.
// Item channel (item_valid/item_stall): one stored byte per transfer, with
// end_of_stream on the frame's last byte and logical_length, which is read
// on the first byte of each frame. Result channel (result_valid/
// result_stall): at most one result per byte - a 32-bit word
// (valid_bytes 4), a tail byte (valid_bytes 1) or a status-only result
// (valid_bytes 0, status parse or bounds error, frame_done set).
// Config channel (cfg_valid/cfg_ready): writes output_capacity; ready is
// always high; write only while the block is idle.
// Throughput: one byte per cycle while result_stall is low, set by the
// decode stage which does one shift, OR and 32-bit add per byte. An input
// byte is written into the queue at its transfer and, once it is at the
// queue head and the result register is free, is decoded into that register.
// A two-entry queue sits between input and decoder; item_stall rises only
// when it is full, so the input keeps flowing while a result waits.
// When result_stall is high the decoder holds, the queue fills and then
// item_stall is raised; nothing is lost.
// Reset clears the queue, the decode state and sets output_capacity to
// 65535.
module delta_zigzag_varint_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [7:0]                  stored_byte,
    input  logic                        end_of_stream,
    input  logic [dzv_pkg::LEN_W-1:0]   logical_length,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dzv_pkg::LEN_W-1:0]   output_capacity,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [dzv_pkg::WORD_W-1:0]  data,
    output logic [2:0]                  valid_bytes,
    output logic [1:0]                  status,
    output logic                        frame_done
);
    import dzv_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // input side: capacity check and queue
    dzv_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .stored_byte    (stored_byte),
        .end_of_stream  (end_of_stream),
        .logical_length (logical_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .output_capacity(output_capacity),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // decode side: varint, delta, tail and result register
    dzv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .data         (data),
        .valid_bytes  (valid_bytes),
        .status       (status),
        .frame_done   (frame_done)
    );

endmodule
